FILE: rtl/pctf_pkg.sv
package pctf_pkg;

	localparam int FIFO_DEPTH  = 512;
	localparam int CHUNK_BYTES = 32;

	localparam int PTR_W     = $clog2(FIFO_DEPTH);
	localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
	localparam int CHUNK_W   = $clog2(CHUNK_BYTES + 1);
	localparam int ELAPSED_W = 17;
	localparam int GAP_W     = 16;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	localparam logic IN_WRITE = 1'b0;
	localparam logic IN_TICK  = 1'b1;

	localparam logic [1:0] RES_ACK   = 2'd0;
	localparam logic [1:0] RES_CHUNK = 2'd1;
	localparam logic [1:0] RES_IDLE  = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] chunk_byte;
		logic       last_in_chunk;
		logic       write_dropped;
		logic       buffer_empty;
	} out_item_t;

endpackage

FILE: rtl/paced_chunk_tx_fifo.sv
// a write acknowledge or an idle tick result is offered in the cycle after the word is
// accepted; each burst byte passes through a read state, which uses the registered read
// port of the byte store, and then a send state that holds while out_stall is high. a new
// input word is taken once the last result of the previous one has been taken.
// reset clears pointers, fill count, elapsed ticks and the gap register; the store is not
// cleared.
module paced_chunk_tx_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pctf_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output pctf_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);
	import pctf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t                state_q;
	logic [7:0]            mem_q [FIFO_DEPTH];
	logic [7:0]            rd_q;
	logic [PTR_W-1:0]      wp_q;
	logic [PTR_W-1:0]      rp_q;
	logic [CNT_W-1:0]      fill_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [GAP_W-1:0]      gap_q;
	logic [CHUNK_W-1:0]    n_q;
	logic                  more_q;
	out_item_t             out_q;

	logic                  accept;
	logic                  full;
	logic                  mem_we;
	logic [CNT_W-1:0]      fill_dec;
	logic [CNT_W-1:0]      fill_inc;
	logic [ELAPSED_W-1:0]  elapsed_next;
	logic                  send_now;
	logic                  last_byte;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_stall     = (state_q != ST_IDLE);
	assign accept       = in_valid && !in_stall;
	assign full         = (fill_q == CNT_W'(FIFO_DEPTH));
	assign mem_we       = accept && (in_item.kind == IN_WRITE) && !full;
	assign fill_dec     = fill_q - 1'b1;
	assign fill_inc     = fill_q + 1'b1;
	assign elapsed_next = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign send_now     = (fill_q != '0) && (elapsed_next > ELAPSED_W'(gap_q));
	assign last_byte    = (n_q + 1'b1 == CHUNK_W'(CHUNK_BYTES)) || (fill_dec == '0);

	assign out_valid = (state_q == ST_SEND);
	assign out_item  = out_q;

	// byte store, registered read port follows the read pointer
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wp_q] <= in_item.data_byte;
		end
		rd_q <= mem_q[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (cfg_we) begin
			gap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			fill_q    <= '0;
			elapsed_q <= '0;
			n_q       <= '0;
			more_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_item.kind == IN_WRITE) begin
							if (!full) begin
								wp_q   <= next_ptr(wp_q);
								fill_q <= fill_inc;
							end
							more_q  <= 1'b0;
							state_q <= ST_SEND;
						end else if (send_now) begin
							elapsed_q <= '0;
							n_q       <= '0;
							state_q   <= ST_READ;
						end else begin
							elapsed_q <= elapsed_next;
							more_q    <= 1'b0;
							state_q   <= ST_SEND;
						end
					end
				end
				ST_READ: begin
					rp_q    <= next_ptr(rp_q);
					fill_q  <= fill_dec;
					n_q     <= n_q + 1'b1;
					more_q  <= !last_byte;
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (!out_stall) begin
						state_q <= more_q ? ST_READ : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					out_q.chunk_byte    <= '0;
					out_q.last_in_chunk <= 1'b0;
					if (in_item.kind == IN_WRITE) begin
						out_q.result_kind   <= RES_ACK;
						out_q.write_dropped <= full;
						out_q.buffer_empty  <= full ? (fill_q == '0) : (fill_inc == '0);
					end else begin
						out_q.result_kind   <= RES_IDLE;
						out_q.write_dropped <= 1'b0;
						out_q.buffer_empty  <= (fill_q == '0);
					end
				end
			end
			ST_READ: begin
				out_q.result_kind   <= RES_CHUNK;
				out_q.chunk_byte    <= rd_q;
				out_q.last_in_chunk <= last_byte;
				out_q.write_dropped <= 1'b0;
				out_q.buffer_empty  <= (fill_dec == '0);
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

endmodule
